@@ rtl/core/prescaled_countdown_timer_unit_defines.svh @@
// Assertion macros for the prescaled countdown timer.
// Included by the top level; depends on nothing else.
`ifndef PRESCALED_COUNTDOWN_TIMER_UNIT_DEFINES_SVH
`define PRESCALED_COUNTDOWN_TIMER_UNIT_DEFINES_SVH

// Check that expr holds in the same cycle whenever cond holds.
`define PCT_ASSERT_IMPLY(label, clk_sig, rst_sig, cond, expr, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |-> (expr)) \
    else $error(msg);

// Check that expr holds in the cycle after cond.
`define PCT_ASSERT_NEXT(label, clk_sig, rst_sig, cond, expr, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ rtl/core/pct_pkg.sv @@
// Shared types and constants of the prescaled countdown timer.
// Used by pct_core and prescaled_countdown_timer_unit; depends on nothing.
package pct_pkg;

  localparam int COUNT_W = 23;
  localparam int DATA_W  = 23;
  localparam int PHASE_W = 8;

  localparam logic [PHASE_W-1:0] DIV16_LAST  = PHASE_W'(15);
  localparam logic [PHASE_W-1:0] DIV256_LAST = PHASE_W'(255);

  localparam int CTRL_LEVEL_BIT  = 0;
  localparam int CTRL_DIV_LSB    = 2;
  localparam int CTRL_RELOAD_BIT = 6;
  localparam int CTRL_ENABLE_BIT = 7;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_LOAD      = 2'd0,
    REG_COUNT     = 2'd1,
    REG_CONTROL   = 2'd2,
    REG_IRQ_CLEAR = 2'd3
  } reg_addr_t;

  typedef enum logic [1:0] {
    DIV_1   = 2'd0,
    DIV_16  = 2'd1,
    DIV_256 = 2'd2
  } div_t;

  typedef struct packed {
    op_t               op;
    reg_addr_t         addr;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_level;
    logic              irq_pulse;
  } result_t;

  typedef struct packed {
    div_t               div;
    logic [PHASE_W-1:0] phase;
  } status_t;

endpackage

@@ rtl/core/prescaled_countdown_timer_unit.sv @@
// Top level of the prescaled countdown timer: input register, timer core,
// result register. Depends on pct_pkg, pct_core and the assertion header.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   cmd     | cmd_valid, cmd_stall, operation, address, | in
//           | write_data                                |
//   rsp     | rsp_valid, rsp_stall, read_data,          | out
//           | irq_level, irq_pulse                      |
//
// One item enters per cycle while cmd_stall is low; its result shows on rsp
// once it leaves the input register (the core works on it there, and the
// result register takes it when not stalled). The core's update sets the rate.
// Reset clears the timer state and both valid flags.
// A stall on rsp holds the result register and, once the input register is
// full behind it, raises cmd_stall in the same cycle.

`include "prescaled_countdown_timer_unit_defines.svh"

module prescaled_countdown_timer_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic [1:0]                 operation,
  input  logic [1:0]                 address,
  input  logic [pct_pkg::DATA_W-1:0] write_data,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [pct_pkg::DATA_W-1:0] read_data,
  output logic                       irq_level,
  output logic                       irq_pulse
);

  // Input register: one item waiting for the core.
  logic             s1_valid;
  pct_pkg::item_t   s1_item;

  // Result register.
  pct_pkg::result_t res_q;

  pct_pkg::result_t core_result;
  pct_pkg::status_t core_status;
  logic             out_ready;
  logic             advance;

  // The result register takes a new item when empty or being drained.
  assign out_ready = !rsp_valid || !rsp_stall;
  // Advance the item in the input register through the core into the result.
  assign advance   = s1_valid && out_ready;
  // Hold the sender off only while the input register cannot move.
  assign cmd_stall = s1_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      s1_item.op   <= pct_pkg::op_t'(operation);
      s1_item.addr <= pct_pkg::reg_addr_t'(address);
      s1_item.data <= write_data;
    end
  end

  // Timer state is updated exactly once per item, when it moves to the result.
  pct_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .result  (core_result),
    .status  (core_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_ready) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= core_result;
    end
  end

  assign read_data = res_q.read_data;
  assign irq_level = res_q.irq_level;
  assign irq_pulse = res_q.irq_pulse;

  // A pulse comes only from a tick, which never returns read data.
  `PCT_ASSERT_IMPLY(a_pulse_no_data, clk, rst, rsp_valid && irq_pulse,
                    read_data == '0, "pulse with read data")
  // Divide by one never leaves the prescaler off phase zero.
  `PCT_ASSERT_IMPLY(a_div1_phase, clk, rst, core_status.div == pct_pkg::DIV_1,
                    core_status.phase == '0, "prescaler moved at divide by one")
  // Divide by sixteen keeps the phase below sixteen.
  `PCT_ASSERT_IMPLY(a_div16_phase, clk, rst, core_status.div == pct_pkg::DIV_16,
                    core_status.phase <= pct_pkg::DIV16_LAST, "prescaler phase out of range")
  // An item stalled at the input has been moved into the result next cycle
  // once the output drains.
  `PCT_ASSERT_NEXT(a_drain_moves, clk, rst, s1_valid && out_ready, rsp_valid,
                   "item lost between stages")

endmodule

@@ rtl/core/pct_core.sv @@
// Timer state and per-item update: registers, prescaler and counter.
// Depends on pct_pkg.
module pct_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  pct_pkg::item_t   item,
  output pct_pkg::result_t result,
  output pct_pkg::status_t status
);

  logic [pct_pkg::COUNT_W-1:0] reload_value, reload_value_next;
  logic [pct_pkg::COUNT_W-1:0] current_count, current_count_next;
  logic [pct_pkg::PHASE_W-1:0] prescale_phase, prescale_phase_next;
  pct_pkg::div_t               divider_select, divider_select_next;
  logic                        level_mode, level_mode_next;
  logic                        reload_enable, reload_enable_next;
  logic                        run_enable, run_enable_next;
  logic                        irq_line, irq_line_next;

  logic [pct_pkg::COUNT_W-1:0] count_dec;
  logic [pct_pkg::DATA_W-1:0]  ctrl_word;
  logic [pct_pkg::DATA_W-1:0]  rd;
  logic                        pulse;
  logic                        phase_more;
  logic [1:0]                  div_code;

  assign count_dec = current_count - pct_pkg::COUNT_W'(1);
  assign div_code  = item.data[pct_pkg::CTRL_DIV_LSB +: 2];

  always_comb begin
    ctrl_word = '0;
    ctrl_word[pct_pkg::CTRL_LEVEL_BIT]      = level_mode;
    ctrl_word[pct_pkg::CTRL_DIV_LSB +: 2]   = divider_select;
    ctrl_word[pct_pkg::CTRL_RELOAD_BIT]     = reload_enable;
    ctrl_word[pct_pkg::CTRL_ENABLE_BIT]     = run_enable;
  end

  always_comb begin
    case (divider_select)
      pct_pkg::DIV_1:  phase_more = 1'b0;
      pct_pkg::DIV_16: phase_more = (prescale_phase < pct_pkg::DIV16_LAST);
      default:         phase_more = (prescale_phase != pct_pkg::DIV256_LAST);
    endcase
  end

  always_comb begin
    reload_value_next   = reload_value;
    current_count_next  = current_count;
    prescale_phase_next = prescale_phase;
    divider_select_next = divider_select;
    level_mode_next     = level_mode;
    reload_enable_next  = reload_enable;
    run_enable_next     = run_enable;
    irq_line_next       = irq_line;
    rd                  = '0;
    pulse               = 1'b0;
    case (item.op)
      pct_pkg::OP_TICK: begin
        if (run_enable && (current_count != '0)) begin
          if (phase_more) begin
            prescale_phase_next = prescale_phase + pct_pkg::PHASE_W'(1);
          end else begin
            prescale_phase_next = '0;
            current_count_next  = count_dec;
            if (count_dec == '0) begin
              if (level_mode) begin
                irq_line_next = 1'b1;
              end else begin
                pulse = 1'b1;
              end
              if (reload_enable) begin
                current_count_next = reload_value;
              end
            end
          end
        end
      end
      pct_pkg::OP_READ: begin
        case (item.addr)
          pct_pkg::REG_LOAD:    rd = pct_pkg::DATA_W'(reload_value);
          pct_pkg::REG_COUNT:   rd = pct_pkg::DATA_W'(current_count);
          pct_pkg::REG_CONTROL: rd = ctrl_word;
          default:              rd = '0;
        endcase
      end
      pct_pkg::OP_WRITE: begin
        case (item.addr)
          pct_pkg::REG_LOAD: begin
            reload_value_next   = pct_pkg::COUNT_W'(item.data);
            current_count_next  = pct_pkg::COUNT_W'(item.data);
            prescale_phase_next = '0;
          end
          pct_pkg::REG_CONTROL: begin
            divider_select_next = (div_code == 2'b11) ? pct_pkg::DIV_256
                                                      : pct_pkg::div_t'(div_code);
            level_mode_next     = item.data[pct_pkg::CTRL_LEVEL_BIT];
            reload_enable_next  = item.data[pct_pkg::CTRL_RELOAD_BIT];
            run_enable_next     = item.data[pct_pkg::CTRL_ENABLE_BIT];
            current_count_next  = (current_count != '0) ? current_count : reload_value;
            prescale_phase_next = '0;
          end
          pct_pkg::REG_IRQ_CLEAR: irq_line_next = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value   <= '0;
      current_count  <= '0;
      prescale_phase <= '0;
      divider_select <= pct_pkg::DIV_1;
      level_mode     <= 1'b0;
      reload_enable  <= 1'b0;
      run_enable     <= 1'b0;
      irq_line       <= 1'b0;
    end else if (advance) begin
      reload_value   <= reload_value_next;
      current_count  <= current_count_next;
      prescale_phase <= prescale_phase_next;
      divider_select <= divider_select_next;
      level_mode     <= level_mode_next;
      reload_enable  <= reload_enable_next;
      run_enable     <= run_enable_next;
      irq_line       <= irq_line_next;
    end
  end

  assign result.read_data = rd;
  assign result.irq_level = irq_line_next;
  assign result.irq_pulse = pulse;
  assign status.div       = divider_select;
  assign status.phase     = prescale_phase;

endmodule
